[src/cfpp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package cfpp_pkg;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        PH_MAGIC,
        PH_MINOR,
        PH_MAJOR,
        PH_COUNT,
        PH_TAG,
        PH_FIELD,
        PH_UTF8,
        PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        KIND_MAGIC,
        KIND_MINOR,
        KIND_MAJOR,
        KIND_COUNT,
        KIND_FIELD,
        KIND_UTF8,
        KIND_ERROR
    } t_kind;

    localparam logic [7:0] TAG_UTF8          = 8'd1;
    localparam logic [7:0] TAG_INTEGER       = 8'd3;
    localparam logic [7:0] TAG_FLOAT         = 8'd4;
    localparam logic [7:0] TAG_LONG          = 8'd5;
    localparam logic [7:0] TAG_DOUBLE        = 8'd6;
    localparam logic [7:0] TAG_CLASS         = 8'd7;
    localparam logic [7:0] TAG_STRING        = 8'd8;
    localparam logic [7:0] TAG_FIELDREF      = 8'd9;
    localparam logic [7:0] TAG_METHODREF     = 8'd10;
    localparam logic [7:0] TAG_IFMETHODREF   = 8'd11;
    localparam logic [7:0] TAG_NAMEANDTYPE   = 8'd12;
    localparam logic [7:0] TAG_METHODHANDLE  = 8'd15;
    localparam logic [7:0] TAG_METHODTYPE    = 8'd16;
    localparam logic [7:0] TAG_INVOKEDYNAMIC = 8'd18;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] num;
        logic [7:0]  tag;
        logic [1:0]  slot;
        logic [31:0] val;
        logic        last;
        logic        done;
    } t_record;

    // byte count of field slot s for tag t; 0 when the slot does not exist
    function automatic logic [2:0] field_width(input logic [7:0] t, input logic [1:0] s);
        logic [2:0] w;
        w = 3'd0;
        unique case (t)
            TAG_UTF8, TAG_CLASS, TAG_STRING, TAG_METHODTYPE:
                w = (s == 2'd0) ? 3'd2 : 3'd0;
            TAG_INTEGER, TAG_FLOAT:
                w = (s == 2'd0) ? 3'd4 : 3'd0;
            TAG_LONG, TAG_DOUBLE:
                w = (s < 2'd2) ? 3'd4 : 3'd0;
            TAG_FIELDREF, TAG_METHODREF, TAG_IFMETHODREF, TAG_NAMEANDTYPE,
            TAG_INVOKEDYNAMIC:
                w = (s < 2'd2) ? 3'd2 : 3'd0;
            TAG_METHODHANDLE:
                w = (s == 2'd0) ? 3'd1 : ((s == 2'd1) ? 3'd2 : 3'd0);
            default:
                w = 3'd0;
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

[src/cfpp_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module cfpp_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_acc,
    input  wire logic [7:0]        i_byte,
    input  wire logic              i_start,
    output cfpp_pkg::t_record      o_rec,
    output logic                   o_push
);
    import cfpp_pkg::*;

    t_phase      r_phase, n_phase, e_phase;
    logic [2:0]  r_bif, n_bif, e_bif;
    logic [31:0] r_asm, n_asm, e_asm;
    logic [15:0] r_total, n_total, e_total;
    logic [15:0] r_index, n_index, e_index;
    logic [7:0]  r_tag, n_tag, e_tag;
    logic [1:0]  r_slot, n_slot, e_slot;
    logic [15:0] r_utf, n_utf, e_utf;
    logic        r_stop, n_stop, e_stop;

    t_record     rec;
    logic        has_rec;

    logic [31:0] asm_next;
    logic [2:0]  bif_inc;
    logic        hdr_full;
    logic        fld_full;
    logic        known_tag;
    logic        last_field;
    logic [15:0] rem_dec;
    logic [16:0] next_idx;
    logic        pool_end;
    t_phase      fin_phase;

    // a start byte sees the reset state
    always_comb begin
        if (i_start) begin
            e_phase = PH_MAGIC;
            e_bif   = 3'd0;
            e_asm   = 32'd0;
            e_total = 16'd0;
            e_index = 16'd1;
            e_tag   = 8'd0;
            e_slot  = 2'd0;
            e_utf   = 16'd0;
            e_stop  = 1'b0;
        end else begin
            e_phase = r_phase;
            e_bif   = r_bif;
            e_asm   = r_asm;
            e_total = r_total;
            e_index = r_index;
            e_tag   = r_tag;
            e_slot  = r_slot;
            e_utf   = r_utf;
            e_stop  = r_stop;
        end
    end

    assign asm_next   = {e_asm[23:0], i_byte};
    assign bif_inc    = e_bif + 3'd1;
    assign hdr_full   = (bif_inc == ((e_phase == PH_MAGIC) ? 3'd4 : 3'd2));
    assign fld_full   = (bif_inc == field_width(e_tag, e_slot));
    assign known_tag  = (field_width(i_byte, 2'd0) != 3'd0);
    assign last_field = (field_width(e_tag, 2'(e_slot + 2'd1)) == 3'd0);
    assign rem_dec    = e_utf - 16'd1;
    assign next_idx   = {1'b0, e_index} +
                        (((e_tag == TAG_LONG) || (e_tag == TAG_DOUBLE)) ? 17'd2 : 17'd1);
    assign pool_end   = (next_idx >= {1'b0, e_total});
    assign fin_phase  = pool_end ? PH_DONE : PH_TAG;

    always_comb begin
        n_phase = e_phase;
        unique case (e_phase)
            PH_MAGIC: if (hdr_full) n_phase = PH_MINOR;
            PH_MINOR: if (hdr_full) n_phase = PH_MAJOR;
            PH_MAJOR: if (hdr_full) n_phase = PH_COUNT;
            PH_COUNT: begin
                if (hdr_full) n_phase = (asm_next[15:0] <= 16'd1) ? PH_DONE : PH_TAG;
            end
            PH_TAG: if (known_tag) n_phase = PH_FIELD;
            PH_FIELD: begin
                if (fld_full) begin
                    if (e_tag == TAG_UTF8) begin
                        n_phase = (asm_next[15:0] == 16'd0) ? fin_phase : PH_UTF8;
                    end else if (last_field) begin
                        n_phase = fin_phase;
                    end
                end
            end
            PH_UTF8: if (rem_dec == 16'd0) n_phase = fin_phase;
            PH_DONE: n_phase = PH_DONE;
        endcase
        if (e_stop) n_phase = e_phase;
    end

    always_comb begin
        n_bif   = e_bif;
        n_asm   = e_asm;
        n_total = e_total;
        n_index = e_index;
        n_tag   = e_tag;
        n_slot  = e_slot;
        n_utf   = e_utf;
        n_stop  = e_stop;
        rec     = '0;
        has_rec = 1'b0;
        if (!e_stop) begin
            unique case (e_phase)
                PH_MAGIC, PH_MINOR, PH_MAJOR, PH_COUNT: begin
                    n_asm = asm_next;
                    n_bif = bif_inc;
                    if (hdr_full) begin
                        n_asm    = 32'd0;
                        n_bif    = 3'd0;
                        has_rec  = 1'b1;
                        rec.kind = t_kind'(e_phase);
                        rec.val  = asm_next;
                        if (e_phase == PH_COUNT) begin
                            n_total  = asm_next[15:0];
                            n_index  = 16'd1;
                            rec.done = (asm_next[15:0] <= 16'd1);
                        end
                    end
                end
                PH_TAG: begin
                    if (known_tag) begin
                        n_tag  = i_byte;
                        n_slot = 2'd0;
                        n_bif  = 3'd0;
                        n_asm  = 32'd0;
                    end else begin
                        n_stop   = 1'b1;
                        has_rec  = 1'b1;
                        rec.kind = KIND_ERROR;
                        rec.num  = e_index;
                        rec.tag  = i_byte;
                        rec.val  = {24'd0, i_byte};
                    end
                end
                PH_FIELD: begin
                    n_asm = asm_next;
                    n_bif = bif_inc;
                    if (fld_full) begin
                        n_asm    = 32'd0;
                        n_bif    = 3'd0;
                        has_rec  = 1'b1;
                        rec.kind = KIND_FIELD;
                        rec.num  = e_index;
                        rec.tag  = e_tag;
                        rec.slot = e_slot;
                        rec.val  = asm_next;
                        if (e_tag == TAG_UTF8) begin
                            n_utf = asm_next[15:0];
                            if (asm_next[15:0] == 16'd0) begin
                                rec.last = 1'b1;
                                rec.done = pool_end;
                                n_slot   = 2'd0;
                                if (!pool_end) n_index = next_idx[15:0];
                            end
                        end else if (last_field) begin
                            rec.last = 1'b1;
                            rec.done = pool_end;
                            n_slot   = 2'd0;
                            if (!pool_end) n_index = next_idx[15:0];
                        end else begin
                            n_slot = 2'(e_slot + 2'd1);
                        end
                    end
                end
                PH_UTF8: begin
                    n_utf    = rem_dec;
                    has_rec  = 1'b1;
                    rec.kind = KIND_UTF8;
                    rec.num  = e_index;
                    rec.tag  = e_tag;
                    rec.slot = 2'd1;
                    rec.val  = {24'd0, i_byte};
                    if (rem_dec == 16'd0) begin
                        rec.last = 1'b1;
                        rec.done = pool_end;
                        n_slot   = 2'd0;
                        n_bif    = 3'd0;
                        n_asm    = 32'd0;
                        if (!pool_end) n_index = next_idx[15:0];
                    end
                end
                PH_DONE: begin
                    has_rec = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MAGIC;
            r_bif   <= 3'd0;
            r_asm   <= 32'd0;
            r_total <= 16'd0;
            r_index <= 16'd1;
            r_tag   <= 8'd0;
            r_slot  <= 2'd0;
            r_utf   <= 16'd0;
            r_stop  <= 1'b0;
        end else if (i_acc) begin
            r_phase <= n_phase;
            r_bif   <= n_bif;
            r_asm   <= n_asm;
            r_total <= n_total;
            r_index <= n_index;
            r_tag   <= n_tag;
            r_slot  <= n_slot;
            r_utf   <= n_utf;
            r_stop  <= n_stop;
        end
    end

    assign o_rec  = rec;
    assign o_push = i_acc & has_rec;

endmodule
`default_nettype wire

[src/cfpp_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
module cfpp_queue #(
    parameter int DEPTH = cfpp_pkg::QUEUE_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire cfpp_pkg::t_record i_rec,
    output logic                   o_full,
    output logic                   o_valid,
    input  wire logic              i_pop,
    output cfpp_pkg::t_record      o_rec
);
    import cfpp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_record            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, n_wr;
    logic [PTR_W-1:0]   r_rd, n_rd;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;
    assign o_rec   = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_wr + 1'b1);
        if (do_pop)  n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_rd + 1'b1);
        if (do_push && !do_pop) n_cnt = CNT_W'(r_cnt + 1'b1);
        else if (!do_push && do_pop) n_cnt = CNT_W'(r_cnt - 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_rec;
    end

endmodule
`default_nettype wire

[src/class_file_pool_parser_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  handshake                            payload
// s_axis    in   i_s_axis_tvalid / o_s_axis_tready    class file byte, start flag
// m_axis    out  o_m_axis_tvalid / i_m_axis_tready    one parse record per request
//
// One byte per cycle; each byte is parsed in the cycle it is taken.
// Records wait in a QUEUE_DEPTH entry queue; input stalls only when it is full.
// Reset (synchronous, active low) returns the parser to the magic phase
// and empties the queue. Bytes that make no record still need a free slot.
module class_file_pool_parser_core #(
    parameter int QUEUE_DEPTH = cfpp_pkg::QUEUE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] byte_value
    input  wire logic        i_s_axis_tuser,   // [0] start_file
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [15:0] entry_number, [23:16] entry_tag, [25:24] field_slot,
    // [57:26] field_value, [63:58] zero
    output logic [63:0]      o_m_axis_tdata,
    output logic [3:0]       o_m_axis_tuser,   // [2:0] record_kind, [3] pool_done
    output logic             o_m_axis_tlast    // entry_last
);
    import cfpp_pkg::*;

    t_record rec_in, rec_out;
    logic    push, full, acc;

    assign o_s_axis_tready = ~full;
    assign acc             = i_s_axis_tvalid & ~full;

    cfpp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_byte  (i_s_axis_tdata),
        .i_start (i_s_axis_tuser),
        .o_rec   (rec_in),
        .o_push  (push)
    );

    cfpp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (rec_in),
        .o_full  (full),
        .o_valid (o_m_axis_tvalid),
        .i_pop   (i_m_axis_tready),
        .o_rec   (rec_out)
    );

    assign o_m_axis_tdata = {6'd0, rec_out.val, rec_out.slot, rec_out.tag, rec_out.num};
    assign o_m_axis_tuser = {rec_out.done, rec_out.kind};
    assign o_m_axis_tlast = rec_out.last;

endmodule
`default_nettype wire

[sim/class_file_pool_parser_core_tb.sv]
`timescale 1ns / 1ps
module class_file_pool_parser_core_tb;
    import cfpp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES = 400;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata = 8'd0;
    logic        i_s_axis_tuser = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [63:0] o_m_axis_tdata;
    logic [3:0]  o_m_axis_tuser;
    logic        o_m_axis_tlast;

    class_file_pool_parser_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // {start_file, byte_value}
    logic [8:0]  byte_queue[$];
    logic [8:0]  file_buf[$];
    logic [8:0]  next_byte;
    t_record     pool_records[$];

    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          bytes_sent = 0;
    int          fail_count = 0;
    int unsigned cycle_count = 0;
    logic        rx_hold_req = 1'b0;
    int          hold_left = 0;

    // parser shadow state
    t_phase      ph = PH_MAGIC;
    logic [2:0]  nbytes = 3'd0;
    logic [31:0] acc = 32'd0;
    logic [15:0] total = 16'd0;
    logic [15:0] idx = 16'd1;
    logic [7:0]  cur_tag = 8'd0;
    logic [1:0]  cur_slot = 2'd0;
    logic [15:0] utf_left = 16'd0;
    logic        halted = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int field_bytes(input logic [7:0] t, input logic [1:0] s);
        int nfields;
        int w;
        nfields = 0;
        w = 0;
        case (t)
            TAG_METHODHANDLE:
                return (s == 2'd0) ? 1 : ((s == 2'd1) ? 2 : 0);
            TAG_INTEGER, TAG_FLOAT: begin
                nfields = 1;
                w = 4;
            end
            TAG_LONG, TAG_DOUBLE: begin
                nfields = 2;
                w = 4;
            end
            TAG_UTF8, TAG_CLASS, TAG_STRING, TAG_METHODTYPE: begin
                nfields = 1;
                w = 2;
            end
            TAG_FIELDREF, TAG_METHODREF, TAG_IFMETHODREF, TAG_NAMEANDTYPE,
            TAG_INVOKEDYNAMIC: begin
                nfields = 2;
                w = 2;
            end
            default: nfields = 0;
        endcase
        return (int'(s) < nfields) ? w : 0;
    endfunction

    function automatic logic [7:0] tag_at(input int i);
        case (i)
            0:  return TAG_UTF8;
            1:  return TAG_INTEGER;
            2:  return TAG_FLOAT;
            3:  return TAG_LONG;
            4:  return TAG_DOUBLE;
            5:  return TAG_CLASS;
            6:  return TAG_STRING;
            7:  return TAG_FIELDREF;
            8:  return TAG_METHODREF;
            9:  return TAG_IFMETHODREF;
            10: return TAG_NAMEANDTYPE;
            11: return TAG_METHODHANDLE;
            12: return TAG_METHODTYPE;
            default: return TAG_INVOKEDYNAMIC;
        endcase
    endfunction

    function automatic void push_record(input t_kind k, input logic [15:0] n,
                                        input logic [7:0] t, input logic [1:0] s,
                                        input logic [31:0] v, input logic l,
                                        input logic d);
        t_record r;
        r.kind = k;
        r.num  = n;
        r.tag  = t;
        r.slot = s;
        r.val  = v;
        r.last = l;
        r.done = d;
        pool_records.push_back(r);
    endfunction

    // close the current entry, 1 when the pool is complete
    function automatic logic close_entry();
        int nxt;
        nxt = int'(idx) + ((cur_tag == TAG_LONG || cur_tag == TAG_DOUBLE) ? 2 : 1);
        cur_slot = 2'd0;
        nbytes = 3'd0;
        acc = 32'd0;
        if (nxt >= int'(total)) begin
            ph = PH_DONE;
            return 1'b1;
        end
        idx = nxt[15:0];
        ph = PH_TAG;
        return 1'b0;
    endfunction

    task automatic parse_byte(input logic [7:0] b, input logic sf);
        logic [31:0] v;
        logic [15:0] n;
        logic [1:0]  s;
        logic        lst;
        logic        dn;
        int          need;
        t_kind       k;
        if (sf) begin
            ph = PH_MAGIC;
            nbytes = 3'd0;
            acc = 32'd0;
            total = 16'd0;
            idx = 16'd1;
            cur_tag = 8'd0;
            cur_slot = 2'd0;
            utf_left = 16'd0;
            halted = 1'b0;
        end
        if (halted) return;
        case (ph)
            PH_MAGIC, PH_MINOR, PH_MAJOR, PH_COUNT: begin
                acc = {acc[23:0], b};
                nbytes = nbytes + 3'd1;
                need = (ph == PH_MAGIC) ? 4 : 2;
                if (int'(nbytes) >= need) begin
                    v = acc;
                    acc = 32'd0;
                    nbytes = 3'd0;
                    dn = 1'b0;
                    k = KIND_MAGIC;
                    case (ph)
                        PH_MAGIC: begin
                            k = KIND_MAGIC;
                            ph = PH_MINOR;
                        end
                        PH_MINOR: begin
                            k = KIND_MINOR;
                            ph = PH_MAJOR;
                        end
                        PH_MAJOR: begin
                            k = KIND_MAJOR;
                            ph = PH_COUNT;
                        end
                        default: begin
                            k = KIND_COUNT;
                            total = v[15:0];
                            idx = 16'd1;
                            if (total <= 16'd1) begin
                                ph = PH_DONE;
                                dn = 1'b1;
                            end else begin
                                ph = PH_TAG;
                            end
                        end
                    endcase
                    push_record(k, 16'd0, 8'd0, 2'd0, v, 1'b0, dn);
                end
            end
            PH_TAG: begin
                if (field_bytes(b, 2'd0) == 0) begin
                    halted = 1'b1;
                    push_record(KIND_ERROR, idx, b, 2'd0, {24'd0, b}, 1'b0, 1'b0);
                end else begin
                    cur_tag = b;
                    cur_slot = 2'd0;
                    nbytes = 3'd0;
                    acc = 32'd0;
                    ph = PH_FIELD;
                end
            end
            PH_FIELD: begin
                acc = {acc[23:0], b};
                nbytes = nbytes + 3'd1;
                if (int'(nbytes) >= field_bytes(cur_tag, cur_slot)) begin
                    v = acc;
                    acc = 32'd0;
                    nbytes = 3'd0;
                    s = cur_slot;
                    n = idx;
                    lst = 1'b0;
                    dn = 1'b0;
                    if (cur_tag == TAG_UTF8) begin
                        utf_left = v[15:0];
                        if (utf_left == 16'd0) begin
                            lst = 1'b1;
                            dn = close_entry();
                        end else begin
                            ph = PH_UTF8;
                        end
                    end else if (field_bytes(cur_tag, s + 2'd1) == 0) begin
                        lst = 1'b1;
                        dn = close_entry();
                    end else begin
                        cur_slot = s + 2'd1;
                    end
                    push_record(KIND_FIELD, n, cur_tag, s, v, lst, dn);
                end
            end
            PH_UTF8: begin
                n = idx;
                utf_left = utf_left - 16'd1;
                lst = 1'b0;
                dn = 1'b0;
                if (utf_left == 16'd0) begin
                    lst = 1'b1;
                    dn = close_entry();
                end
                push_record(KIND_UTF8, n, cur_tag, 2'd1, {24'd0, b}, lst, dn);
            end
            default: ;
        endcase
    endtask

    task automatic check_record();
        t_record e;
        t_record a;
        logic    bad;
        a.kind = t_kind'(o_m_axis_tuser[2:0]);
        a.num  = o_m_axis_tdata[15:0];
        a.tag  = o_m_axis_tdata[23:16];
        a.slot = o_m_axis_tdata[25:24];
        a.val  = o_m_axis_tdata[57:26];
        a.last = o_m_axis_tlast;
        a.done = o_m_axis_tuser[3];
        if (pool_records.size() == 0) begin
            if (fail_count < 10)
                $display("unexpected record: kind=%0d num=%0d tag=%0d slot=%0d val=%h",
                         a.kind, a.num, a.tag, a.slot, a.val);
            fail_count++;
            return;
        end
        e = pool_records.pop_front();
        bad = (a.kind !== e.kind) || (a.num !== e.num) || (a.tag !== e.tag) ||
              (a.slot !== e.slot) || (a.val !== e.val) || (a.last !== e.last) ||
              (a.done !== e.done) || (o_m_axis_tdata[63:58] !== 6'd0);
        if (bad) begin
            if (fail_count < 10) begin
                $write("mismatch: exp kind=%0d num=%0d tag=%0d slot=%0d val=%h",
                       e.kind, e.num, e.tag, e.slot, e.val);
                $write(" last=%b done=%b | got kind=%0d num=%0d tag=%0d",
                       e.last, e.done, a.kind, a.num, a.tag);
                $display(" slot=%0d val=%h last=%b done=%b pad=%h",
                         a.slot, a.val, a.last, a.done, o_m_axis_tdata[63:58]);
            end
            fail_count++;
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || o_s_axis_tready) begin
            if (byte_queue.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                next_byte = byte_queue.pop_front();
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata <= next_byte[7:0];
                i_s_axis_tuser <= next_byte[8];
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                parse_byte(i_s_axis_tdata, i_s_axis_tuser);
            if (o_m_axis_tvalid && i_m_axis_tready)
                check_record();
        end
        i_m_axis_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (rx_hold_req)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("class_file_pool_parser_core test failed");
            $finish;
        end
    end

    task automatic add_byte(input logic [7:0] b, input logic sf);
        file_buf.push_back({sf, b});
    endtask

    task automatic add_u16(input logic [15:0] v);
        add_byte(v[15:8], 1'b0);
        add_byte(v[7:0], 1'b0);
    endtask

    task automatic add_header(input logic [31:0] m, input logic [15:0] mi,
                              input logic [15:0] ma, input logic [15:0] c);
        add_byte(m[31:24], 1'b1);
        add_byte(m[23:16], 1'b0);
        add_byte(m[15:8], 1'b0);
        add_byte(m[7:0], 1'b0);
        add_u16(mi);
        add_u16(ma);
        add_u16(c);
    endtask

    task automatic add_utf8(input int len);
        add_byte(TAG_UTF8, 1'b0);
        add_u16(len[15:0]);
        repeat (len) add_byte(8'($urandom), 1'b0);
    endtask

    task automatic add_entry(input logic [7:0] t);
        if (t == TAG_UTF8) begin
            add_utf8(($urandom_range(0, 19) == 0) ? $urandom_range(9, 40)
                                                   : $urandom_range(0, 8));
        end else begin
            add_byte(t, 1'b0);
            for (int s = 0; s < 3; s++)
                repeat (field_bytes(t, s[1:0])) add_byte(8'($urandom), 1'b0);
        end
    endtask

    task automatic add_file(input int count, input int max_entries, input logic bad_tag);
        int          i;
        int          n;
        logic [7:0]  t;
        add_header(($urandom_range(0, 3) == 0) ? $urandom : 32'hCAFEBABE,
                   16'($urandom), 16'($urandom_range(45, 70)), count[15:0]);
        i = 1;
        n = 0;
        while (i < count && n < max_entries) begin
            if (bad_tag && $urandom_range(0, 3) == 0) begin
                do t = 8'($urandom); while (field_bytes(t, 2'd0) != 0);
                add_byte(t, 1'b0);
                repeat ($urandom_range(0, 4)) add_byte(8'($urandom), 1'b0);
                break;
            end
            t = tag_at($urandom_range(0, 13));
            add_entry(t);
            i += (t == TAG_LONG || t == TAG_DOUBLE) ? 2 : 1;
            n++;
        end
    endtask

    task automatic send_bytes(input int keep);
        for (int i = 0; i < file_buf.size() && i < keep; i++) begin
            byte_queue.push_back(file_buf[i]);
            bytes_sent++;
        end
        file_buf.delete();
    endtask

    task automatic random_files(input int target);
        int sel;
        int cnt;
        while (bytes_sent < target) begin
            sel = $urandom_range(0, 99);
            cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                              : $urandom_range(0, 10);
            add_file(cnt, 8, sel >= 88 && sel < 94);
            if (sel < 70) begin
                send_bytes(file_buf.size());
            end else if (sel < 80) begin
                repeat ($urandom_range(1, 5)) add_byte(8'($urandom), 1'b0);
                send_bytes(file_buf.size());
            end else if (sel < 88) begin
                send_bytes($urandom_range(1, file_buf.size() - 1));
            end else if (sel < 94) begin
                send_bytes(file_buf.size());
            end else begin
                file_buf.delete();
                repeat ($urandom_range(1, 6))
                    add_byte(8'($urandom), $urandom_range(0, 7) == 0);
                send_bytes(file_buf.size());
            end
        end
    endtask

    task automatic wait_idle();
        while (byte_queue.size() != 0 || i_s_axis_tvalid || pool_records.size() != 0 ||
               hold_left != 0 || rx_hold_req)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle_pct = 25;
        rx_idle_pct = 76;

        // empty pool with count 0, trailing byte ignored
        add_header(32'hFFFFFFFF, 16'h0000, 16'hFFFF, 16'd0);
        add_byte(8'hFF, 1'b0);
        // empty pool with count 1
        add_header(32'hCAFEBABE, 16'd3, 16'd52, 16'd1);
        // empty utf8, a class, then a long in the last slot, then ignored byte
        add_header(32'hCAFEBABE, 16'd0, 16'd61, 16'd4);
        add_utf8(0);
        add_byte(TAG_CLASS, 1'b0);
        add_u16(16'hFFFF);
        add_byte(TAG_LONG, 1'b0);
        repeat (4) add_byte(8'h00, 1'b0);
        repeat (4) add_byte(8'hFF, 1'b0);
        add_byte(TAG_CLASS, 1'b0);
        // every tag once, then an unknown tag and bytes swallowed while stopped
        add_header(32'hCAFEBABE, 16'd0, 16'd65, 16'd20);
        for (int i = 0; i < 14; i++) add_entry(tag_at(i));
        add_byte(8'hFF, 1'b0);
        add_byte(TAG_CLASS, 1'b0);
        add_byte(8'h00, 1'b0);
        // restart in the middle of an entry
        add_header(32'hCAFEBABE, 16'd0, 16'd52, 16'd5);
        add_byte(TAG_FIELDREF, 1'b0);
        add_byte(8'h12, 1'b0);
        add_header(32'hCAFEBABE, 16'd0, 16'd52, 16'd2);
        add_entry(TAG_METHODHANDLE);
        send_bytes(file_buf.size());

        random_files(520);
        wait_idle();

        tx_idle_pct = 76;
        rx_idle_pct = 25;
        random_files(1040);
        wait_idle();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_files(1550);
        @(posedge i_clk);
        rx_hold_req <= 1'b1;
        @(posedge i_clk);
        rx_hold_req <= 1'b0;
        wait_idle();

        if (fail_count == 0)
            $display("class_file_pool_parser_core test passed");
        else
            $display("class_file_pool_parser_core test failed");
        $finish;
    end

endmodule
